FILE: sv/pcse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcse_pkg
// Shared constants, operation codes, controller states and the command and
// status bundles of the polynomial coefficient store.
// ----------------------------------------------------------------------------
package pcse_pkg;

   localparam int MaxTermsDef = 64;
   localparam int CoefBitsDef = 32;

   localparam int OpW    = 2;
   localparam int IdxW   = 6;
   localparam int OperW  = 32;
   localparam int ValW   = 64;
   localparam int CharW  = 31;

   localparam logic [OpW-1:0] OP_WRITE = 2'd0;
   localparam logic [OpW-1:0] OP_READ  = 2'd1;
   localparam logic [OpW-1:0] OP_EVAL  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISP,
      ST_W_RD,
      ST_W_SEL,
      ST_W_MOD,
      ST_W_WB,
      ST_W_FIN,
      ST_R_RD,
      ST_E_RD,
      ST_E_MUL1,
      ST_E_MUL2,
      ST_E_ADD,
      ST_E_MOD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic rd;
      logic sel_load;
      logic mod_sel;
      logic mod_sum;
      logic val_mod;
      logic wb;
      logic fin;
      logic mul1;
      logic mul2;
      logic y_sum;
      logic y_mod;
      logic cnt_inc;
      logic cnt_dec;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [OpW-1:0] op;
      logic           wr_bad;
      logic           ev_bad;
      logic           p_zero;
      logic           last;
      logic           mod_done;
      logic           rsp_free;
   } st_type;

endpackage
`default_nettype wire

FILE: sv/pcse_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcse channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcse_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [5:0]  index;
   logic signed [31:0] operand;
   modport source (output valid, operation, index, operand, input ready);
   modport sink   (input valid, operation, index, operand, output ready);
endinterface

interface pcse_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [63:0] value;
   logic [5:0]  degree_now;
   logic        is_monic;
   logic        zero_constant;
   logic        status;
   modport source (output valid, value, degree_now, is_monic, zero_constant, status,
                   input ready);
   modport sink   (input valid, value, degree_now, is_monic, zero_constant, status,
                   output ready);
endinterface

interface pcse_csr_if;
   logic        valid;
   logic        ready;
   logic [30:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: sv/poly_coeff_store_horner_eval_top.sv
`default_nettype none
// Sequence: dispatch; a write reads, selects, may reduce mod p and writes back each term
//   up to the new degree, then sets it; a read fetches its entry; an evaluate reads,
//   multiplies, adds and may reduce each term; then output. Mod-p steps wait on the reducer.
// Throughput: one item at a time; the next item is taken the cycle after the result loads.
// Reset (synchronous): degree, flags and characteristic clear; memory is not swept,
//   entries above the degree read as zero.
// ----------------------------------------------------------------------------
// poly_coeff_store_horner_eval_top
// Polynomial coefficient store with Horner evaluation, optionally mod p.
// ----------------------------------------------------------------------------
module poly_coeff_store_horner_eval_top #(
   parameter int MAX_TERMS = pcse_pkg::MaxTermsDef,
   parameter int COEF_BITS = pcse_pkg::CoefBitsDef
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pcse_req_if.sink    req_chan,
   pcse_rsp_if.source  rsp_chan,
   pcse_csr_if.sink    csr_chan
);
   import pcse_pkg::*;

   cmd_type cmd;
   st_type  st;

   assign csr_chan.ready = !reset;

   pcse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   pcse_dpath #(
      .MAX_TERMS (MAX_TERMS),
      .COEF_BITS (COEF_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_operation     (req_chan.operation),
      .req_index         (req_chan.index),
      .req_operand       (req_chan.operand),
      .csr_valid         (csr_chan.valid),
      .csr_data          (csr_chan.data),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_value         (rsp_chan.value),
      .rsp_degree_now    (rsp_chan.degree_now),
      .rsp_is_monic      (rsp_chan.is_monic),
      .rsp_zero_constant (rsp_chan.zero_constant),
      .rsp_status        (rsp_chan.status)
   );

endmodule
`default_nettype wire

FILE: sv/pcse_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcse_mod
// Serial reduction of a signed 64-bit value into 0..p-1, one dividend bit
// per cycle by restoring subtraction.
// ----------------------------------------------------------------------------
module pcse_mod (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [pcse_pkg::ValW-1:0] dividend,
   input  wire logic [pcse_pkg::CharW-1:0] modulus,
   output logic                           done,
   output logic [pcse_pkg::CharW-1:0]     result
);
   import pcse_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [ValW-1:0]   mag_ff, mag_in;
   logic [CharW-1:0]  rem_ff, rem_in;
   logic              neg_ff, neg_in;
   logic [CharW:0]    trial;

   assign trial = {rem_ff, mag_ff[ValW-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[ValW-1];
         mag_in  = dividend[ValW-1] ? (~dividend + 64'd1) : dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         mag_in = {mag_ff[ValW-2:0], 1'b0};
         if (trial >= {1'b0, modulus}) begin
            rem_in = CharW'(trial - {1'b0, modulus});
         end else begin
            rem_in = trial[CharW-1:0];
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   // negative dividends fold back into range
   assign result = (neg_ff && rem_ff != '0) ? CharW'(modulus - rem_ff) : rem_ff;
   assign done   = done_ff;

endmodule
`default_nettype wire

FILE: sv/pcse_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcse_ctrl
// Sequencer for write sweeps, reads and Horner evaluation.
// ----------------------------------------------------------------------------
module pcse_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pcse_pkg::st_type  st,
   output pcse_pkg::cmd_type      cmd
);
   import pcse_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISP;
            end
         end
         ST_DISP: begin
            case (st.op)
               OP_WRITE: state_in = st.wr_bad ? ST_DONE : ST_W_RD;
               OP_READ:  state_in = ST_R_RD;
               OP_EVAL:  state_in = st.ev_bad ? ST_DONE : ST_E_RD;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_W_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_W_SEL;
         end
         ST_W_SEL: begin
            cmd.sel_load = 1'b1;
            if (st.p_zero) begin
               state_in = ST_W_WB;
            end else begin
               cmd.mod_sel = 1'b1;
               state_in    = ST_W_MOD;
            end
         end
         ST_W_MOD: begin
            if (st.mod_done) begin
               cmd.val_mod = 1'b1;
               state_in    = ST_W_WB;
            end
         end
         ST_W_WB: begin
            cmd.wb = 1'b1;
            if (st.last) begin
               state_in = ST_W_FIN;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = ST_W_RD;
            end
         end
         ST_W_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_DONE;
         end
         ST_R_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_DONE;
         end
         ST_E_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_E_MUL1;
         end
         ST_E_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_E_MUL2;
         end
         ST_E_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_E_ADD;
         end
         ST_E_ADD: begin
            if (st.p_zero) begin
               cmd.y_sum = 1'b1;
               if (st.last) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.cnt_dec = 1'b1;
                  state_in    = ST_E_RD;
               end
            end else begin
               cmd.mod_sum = 1'b1;
               state_in    = ST_E_MOD;
            end
         end
         ST_E_MOD: begin
            if (st.mod_done) begin
               cmd.y_mod = 1'b1;
               if (st.last) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.cnt_dec = 1'b1;
                  state_in    = ST_E_RD;
               end
            end
         end
         ST_DONE: begin
            if (st.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: sv/pcse_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcse_dpath
// Coefficient memory, degree and flag shadows, Horner multiply-add, the
// characteristic register and the response register.
// ----------------------------------------------------------------------------
module pcse_dpath #(
   parameter int MAX_TERMS = pcse_pkg::MaxTermsDef,
   parameter int COEF_BITS = pcse_pkg::CoefBitsDef
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pcse_pkg::cmd_type           cmd,
   output pcse_pkg::st_type                 st,
   input  wire logic [pcse_pkg::OpW-1:0]    req_operation,
   input  wire logic [pcse_pkg::IdxW-1:0]   req_index,
   input  wire logic signed [pcse_pkg::OperW-1:0] req_operand,
   input  wire logic                        csr_valid,
   input  wire logic [pcse_pkg::CharW-1:0]  csr_data,
   input  wire logic                        rsp_ready,
   output logic                             rsp_valid,
   output logic signed [pcse_pkg::ValW-1:0] rsp_value,
   output logic [pcse_pkg::IdxW-1:0]        rsp_degree_now,
   output logic                             rsp_is_monic,
   output logic                             rsp_zero_constant,
   output logic                             rsp_status
);
   import pcse_pkg::*;

   localparam int SB = (COEF_BITS > 32) ? COEF_BITS : 32;
   localparam int AW = $clog2(MAX_TERMS);

   logic [SB-1:0] mem [MAX_TERMS];

   logic [CharW-1:0]    char_ff;
   logic [IdxW-1:0]     degree_ff, newdeg_ff, dnew_ff, cnt_ff, idx_ff;
   logic [OpW-1:0]      op_ff;
   logic signed [OperW-1:0] x_ff;
   logic [SB-1:0]       const_ff, lead_ff, rdata_ff, val_ff, c_ff;
   logic [ValW-1:0]     y_ff, p1_ff;
   logic [31:0]         p2_ff;
   logic                rsp_valid_ff;
   logic signed [ValW-1:0] rsp_value_ff;
   logic                rsp_status_ff;
   logic [IdxW-1:0]     rsp_degree_ff;
   logic                rsp_monic_ff;
   logic                rsp_zconst_ff;

   logic [AW-1:0]       addr;
   logic [SB-1:0]       sel_val, fit_val, term;
   logic signed [ValW:0] prod1;
   logic [31:0]         prod2;
   logic [ValW-1:0]     sum;
   logic                p_zero, wr_bad, ev_bad, rd_bad, mod_done;
   logic [CharW-1:0]    mod_res;
   logic [ValW-1:0]     mod_in;

   assign addr    = AW'(cnt_ff);
   assign p_zero  = (char_ff == '0);
   assign wr_bad  = ({26'd0, idx_ff} >= 32'(MAX_TERMS));
   assign ev_bad  = !p_zero && (x_ff[OperW-1] || ({1'b0, x_ff[OperW-2:0]} >= {1'b0, char_ff}));
   assign rd_bad  = (idx_ff > degree_ff);
   assign fit_val = SB'(COEF_BITS'(x_ff));

   // entries above the old degree count as zero; entry 0 lives in const_ff
   always_comb begin
      if (cnt_ff == idx_ff) begin
         sel_val = fit_val;
      end else if (cnt_ff > degree_ff) begin
         sel_val = '0;
      end else if (cnt_ff == '0) begin
         sel_val = const_ff;
      end else begin
         sel_val = rdata_ff;
      end
   end

   assign term  = (cnt_ff == '0) ? const_ff : rdata_ff;
   assign prod1 = $signed({1'b0, y_ff[31:0]}) * x_ff;
   assign prod2 = y_ff[63:32] * x_ff[31:0];
   assign sum   = p1_ff + {p2_ff, 32'd0} + 64'($signed(c_ff));
   assign mod_in = cmd.mod_sel ? 64'($signed(sel_val)) : sum;

   pcse_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mod_sel | cmd.mod_sum),
      .dividend (mod_in),
      .modulus  (char_ff),
      .done     (mod_done),
      .result   (mod_res)
   );

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff <= mem[addr];
      end
      if (cmd.wb) begin
         mem[addr] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff   <= '0;
         degree_ff <= '0;
         const_ff  <= '0;
         lead_ff   <= '0;
      end else begin
         if (csr_valid) begin
            char_ff <= csr_data;
         end
         if (cmd.wb) begin
            if (cnt_ff == '0) begin
               const_ff <= val_ff;
            end
         end
         if (cmd.wb && (val_ff != '0 || cnt_ff == '0)) begin
            lead_ff <= val_ff;
         end
         if (cmd.fin) begin
            degree_ff <= dnew_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_operation;
         idx_ff    <= req_index;
         x_ff      <= req_operand;
         y_ff      <= '0;
         newdeg_ff <= (req_index > degree_ff) ? req_index : degree_ff;
         case (req_operation)
            OP_READ: cnt_ff <= req_index;
            OP_EVAL: cnt_ff <= degree_ff;
            default: cnt_ff <= '0;
         endcase
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + 6'd1;
      end else if (cmd.cnt_dec) begin
         cnt_ff <= cnt_ff - 6'd1;
      end
      if (cmd.sel_load) begin
         val_ff <= sel_val;
      end else if (cmd.val_mod) begin
         val_ff <= SB'(mod_res);
      end
      if (cmd.wb && (val_ff != '0 || cnt_ff == '0)) begin
         dnew_ff <= cnt_ff;
      end
      if (cmd.mul1) begin
         p1_ff <= prod1[ValW-1:0];
         c_ff  <= term;
      end
      if (cmd.mul2) begin
         p2_ff <= prod2;
      end
      if (cmd.y_sum) begin
         y_ff <= sum;
      end else if (cmd.y_mod) begin
         y_ff <= 64'(mod_res);
      end
   end

   // response register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         // snapshot the flags so a following item cannot change a waiting result
         rsp_degree_ff <= degree_ff;
         rsp_monic_ff  <= (lead_ff == SB'(1));
         rsp_zconst_ff <= (const_ff == '0);
         case (op_ff)
            OP_WRITE: begin
               rsp_value_ff  <= '0;
               rsp_status_ff <= wr_bad;
            end
            OP_READ: begin
               rsp_status_ff <= rd_bad;
               if (rd_bad) begin
                  rsp_value_ff <= '0;
               end else if (idx_ff == '0) begin
                  rsp_value_ff <= 64'($signed(const_ff));
               end else begin
                  rsp_value_ff <= 64'($signed(rdata_ff));
               end
            end
            OP_EVAL: begin
               rsp_status_ff <= ev_bad;
               rsp_value_ff  <= ev_bad ? '0 : $signed(y_ff);
            end
            default: begin
               rsp_status_ff <= 1'b1;
               rsp_value_ff  <= '0;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_degree_now    = rsp_degree_ff;
   assign rsp_is_monic      = rsp_monic_ff;
   assign rsp_zero_constant = rsp_zconst_ff;

   always_comb begin
      st          = '0;
      st.op       = op_ff;
      st.wr_bad   = wr_bad;
      st.ev_bad   = ev_bad;
      st.p_zero   = p_zero;
      st.last     = (op_ff == OP_WRITE) ? (cnt_ff == newdeg_ff) : (cnt_ff == '0);
      st.mod_done = mod_done;
      st.rsp_free = !rsp_valid_ff || rsp_ready;
   end

endmodule
`default_nettype wire
